FILE: rtl/dqd_pkg.sv
package dqd_pkg;

    localparam int LINE_COUNT = 16;
    localparam int LINE_W     = 16;
    localparam int ACC_W      = 3;
    localparam int SUM_W      = ACC_W + 1;
    localparam int STEP_W     = 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic [LINE_W-1:0] LINE_KEEP =
        (LINE_COUNT >= LINE_W) ? {LINE_W{1'b1}} : LINE_W'((1 << LINE_COUNT) - 1);

    localparam logic [LINE_W-1:0] CLK_MASK_RESET = LINE_W'(1);
    localparam logic [LINE_W-1:0] DT_MASK_RESET  = LINE_W'(2);

    localparam logic signed [SUM_W-1:0] ACC_LIMIT_POS = SUM_W'(4);
    localparam logic signed [SUM_W-1:0] ACC_LIMIT_NEG = -SUM_W'(4);

    localparam logic signed [STEP_W-1:0] STEP_NONE = STEP_W'(0);
    localparam logic signed [STEP_W-1:0] STEP_FWD  = STEP_W'(1);
    localparam logic signed [STEP_W-1:0] STEP_REV  = -STEP_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLK_LINE_MASK = 1'b0,
        CFG_DT_LINE_MASK  = 1'b1
    } cfg_idx_t;

    typedef logic signed [STEP_W-1:0] step_t;

    typedef struct packed {
        logic [LINE_W-1:0] clk_bits;
        logic [LINE_W-1:0] dt_bits;
    } line_sel_t;

    localparam step_t GRAY_STEP_TABLE [16] = '{
        STEP_NONE, STEP_REV,  STEP_FWD,  STEP_NONE,
        STEP_FWD,  STEP_NONE, STEP_NONE, STEP_REV,
        STEP_REV,  STEP_NONE, STEP_NONE, STEP_FWD,
        STEP_NONE, STEP_FWD,  STEP_REV,  STEP_NONE
    };

endpackage

FILE: rtl/dqd_debounce.sv
module dqd_debounce
    import dqd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              enable,
    input  logic [LINE_W-1:0] raw_lines,
    output logic [LINE_W-1:0] stable_next,
    output logic [LINE_W-1:0] pressed_next
);

    logic [LINE_W-1:0] candidate_reg;
    logic [LINE_W-1:0] candidate_next;
    logic [LINE_W-1:0] stable_reg;

    always_comb begin
        candidate_next = candidate_reg;
        stable_next    = stable_reg;
        if (raw_lines == candidate_reg) begin
            stable_next = raw_lines;
        end else begin
            candidate_next = raw_lines;
        end
        pressed_next = ~stable_reg & stable_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            candidate_reg <= '0;
            stable_reg    <= '0;
        end else if (enable) begin
            candidate_reg <= candidate_next;
            stable_reg    <= stable_next;
        end
    end

endmodule

FILE: rtl/dqd_quadrature.sv
module dqd_quadrature
    import dqd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              enable,
    input  line_sel_t         line_sel,
    input  logic [LINE_W-1:0] stable_lines,
    output step_t             step_next
);

    logic [1:0]              phase_reg;
    logic [1:0]              phase_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [SUM_W-1:0] acc_sum;
    logic [3:0]              table_idx;

    always_comb begin
        phase_next = {|(stable_lines & line_sel.clk_bits), |(stable_lines & line_sel.dt_bits)};
        table_idx  = {phase_reg, phase_next};
        acc_sum    = SUM_W'(acc_reg) + SUM_W'(GRAY_STEP_TABLE[table_idx]);
        step_next  = STEP_NONE;
        acc_next   = acc_sum[ACC_W-1:0];
        if (acc_sum >= ACC_LIMIT_POS) begin
            step_next = STEP_FWD;
            acc_next  = '0;
        end else if (acc_sum <= ACC_LIMIT_NEG) begin
            step_next = STEP_REV;
            acc_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            acc_reg   <= '0;
        end else if (enable) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
        end
    end

    // accumulator stays within -3..+3 between samples
    a_acc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg != {1'b1, {(ACC_W-1){1'b0}}})
        else $error("phase accumulator out of range");

endmodule

FILE: rtl/debounce_quadrature_decoder_top.sv
// an accepted sample is held in the input register, then in the result register that drives the result ports
// throughput: one sample per cycle while m_ready does not stall the result stage, input register then result register
// ready stays high unless both stages hold transactions and m_ready is low
// reset: aresetn synchronous active low, clears state, empties both stages,
// sets clk_line_mask to 1 and dt_line_mask to 2
module debounce_quadrature_decoder_top
    import dqd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LINE_W-1:0]    cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [LINE_W-1:0]    s_raw_lines,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [LINE_W-1:0]    m_stable_lines,
    output logic [LINE_W-1:0]    m_pressed_lines,
    output step_t                m_rotation_step
);

    line_sel_t         line_sel_reg;
    logic              in_valid_reg;
    logic [LINE_W-1:0] raw_reg;
    logic              out_valid_reg;
    logic [LINE_W-1:0] stable_out_reg;
    logic [LINE_W-1:0] pressed_out_reg;
    step_t             step_out_reg;
    logic              advance;
    logic [LINE_W-1:0] stable_next;
    logic [LINE_W-1:0] pressed_next;
    step_t             step_next;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_sel_reg.clk_bits <= CLK_MASK_RESET;
            line_sel_reg.dt_bits  <= DT_MASK_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CLK_LINE_MASK: line_sel_reg.clk_bits <= cfg_data;
                CFG_DT_LINE_MASK:  line_sel_reg.dt_bits  <= cfg_data;
                default:           line_sel_reg          <= line_sel_reg;
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            raw_reg <= s_raw_lines & LINE_KEEP;
        end
    end

    dqd_debounce u_debounce (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .enable       (in_valid_reg && advance),
        .raw_lines    (raw_reg),
        .stable_next  (stable_next),
        .pressed_next (pressed_next)
    );

    dqd_quadrature u_quadrature (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .enable       (in_valid_reg && advance),
        .line_sel     (line_sel_reg),
        .stable_lines (stable_next),
        .step_next    (step_next)
    );

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            stable_out_reg  <= stable_next;
            pressed_out_reg <= pressed_next;
            step_out_reg    <= step_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_stable_lines  = stable_out_reg;
    assign m_pressed_lines = pressed_out_reg;
    assign m_rotation_step = step_out_reg;

    a_pressed_subset: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((pressed_out_reg & ~stable_out_reg) == '0))
        else $error("pressed lines not within stable lines");

    a_step_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (step_out_reg != {1'b1, 1'b0}))
        else $error("illegal rotation step code");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled with room in the pipeline");

    a_reset_empty: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> (!in_valid_reg && !out_valid_reg))
        else $error("pipeline not empty after reset");

endmodule
